@@ rtl/core/tfn_pkg.sv @@
// Package for the triangle face normal block: widths and constants of the
// snorm16 normalisation. No dependencies.
package tfn_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int INDEX_WIDTH     = 32;
  localparam int NORMAL_WIDTH    = 16;
  localparam int SNORM_BITS      = 15;

endpackage

@@ rtl/core/triangle_face_normal_snorm16.sv @@
// Triangle face normal, snorm16: edges, exact cross product, exact
// normalisation by bit-serial search unrolled into pipeline stages.
// Depends on tfn_pkg.
// Pipeline: start passes through 7 arithmetic stages, 15 search stages and the
// output stage, whose register drives done.
// Throughput: one triangle per cycle; busy is always low and the receiver
// cannot stall, so the pipeline advances on every edge.
// Reset: synchronous rst clears the valid bits of every stage and done.
module triangle_face_normal_snorm16 import tfn_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [INDEX_WIDTH-1:0]         index_a,
  input  logic [INDEX_WIDTH-1:0]         index_b,
  input  logic [INDEX_WIDTH-1:0]         index_c,
  input  logic signed [FIELD_WIDTH-1:0]  ax,
  input  logic signed [FIELD_WIDTH-1:0]  ay,
  input  logic signed [FIELD_WIDTH-1:0]  az,
  input  logic signed [FIELD_WIDTH-1:0]  bx,
  input  logic signed [FIELD_WIDTH-1:0]  by_coord,
  input  logic signed [FIELD_WIDTH-1:0]  bz,
  input  logic signed [FIELD_WIDTH-1:0]  cx,
  input  logic signed [FIELD_WIDTH-1:0]  cy,
  input  logic signed [FIELD_WIDTH-1:0]  cz,
  output logic                           done,
  output logic signed [NORMAL_WIDTH-1:0] normal_x,
  output logic signed [NORMAL_WIDTH-1:0] normal_y,
  output logic signed [NORMAL_WIDTH-1:0] normal_z,
  output logic [INDEX_WIDTH-1:0]         out_index_a,
  output logic [INDEX_WIDTH-1:0]         out_index_b,
  output logic [INDEX_WIDTH-1:0]         out_index_c
);

  localparam int W    = COORD_WIDTH;
  localparam int E    = W + 1;
  localparam int MW   = 2 * E;
  localparam int SQW  = 2 * MW;
  localparam int SW   = SQW + 2;
  localparam int CW   = SW + 2 * SNORM_BITS;
  localparam int QW   = SW + SNORM_BITS;
  localparam int ITER = SNORM_BITS;
  localparam int NST  = 7;
  localparam int LATENCY = NST + ITER + 1;

  assign busy = 1'b0;

  // stage 0: capture
  logic                   v0;
  logic signed [W-1:0]    c0 [0:8];
  logic [INDEX_WIDTH-1:0] i0 [0:2];

  always_ff @(posedge clk) begin
    v0 <= rst ? 1'b0 : start;
    c0[0] <= ax[W-1:0];
    c0[1] <= ay[W-1:0];
    c0[2] <= az[W-1:0];
    c0[3] <= bx[W-1:0];
    c0[4] <= by_coord[W-1:0];
    c0[5] <= bz[W-1:0];
    c0[6] <= cx[W-1:0];
    c0[7] <= cy[W-1:0];
    c0[8] <= cz[W-1:0];
    i0[0] <= index_a;
    i0[1] <= index_b;
    i0[2] <= index_c;
  end

  // stage 1: edges C-B and A-B
  logic                   v1;
  logic signed [E-1:0]    e1 [0:2];
  logic signed [E-1:0]    e2 [0:2];
  logic [INDEX_WIDTH-1:0] i1 [0:2];

  always_ff @(posedge clk) begin
    v1 <= rst ? 1'b0 : v0;
    for (int k = 0; k < 3; k++) begin
      e1[k] <= {c0[6+k][W-1], c0[6+k]} - {c0[3+k][W-1], c0[3+k]};
      e2[k] <= {c0[k][W-1], c0[k]} - {c0[3+k][W-1], c0[3+k]};
    end
    i1 <= i0;
  end

  // stage 2: six products
  logic                   v2;
  logic signed [MW-1:0]   pa [0:2];
  logic signed [MW-1:0]   pb [0:2];
  logic [INDEX_WIDTH-1:0] i2 [0:2];

  always_ff @(posedge clk) begin
    v2 <= rst ? 1'b0 : v1;
    pa[0] <= e1[1] * e2[2];
    pb[0] <= e1[2] * e2[1];
    pa[1] <= e1[2] * e2[0];
    pb[1] <= e1[0] * e2[2];
    pa[2] <= e1[0] * e2[1];
    pb[2] <= e1[1] * e2[0];
    i2 <= i1;
  end

  // stage 3: cross terms as sign and magnitude
  logic                   v3;
  logic [2:0]             neg3;
  logic [MW-1:0]          mag3 [0:2];
  logic [INDEX_WIDTH-1:0] i3 [0:2];
  logic [MW:0]            diff [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {pa[k][MW-1], pa[k]} - {pb[k][MW-1], pb[k]};
    end
  end

  always_ff @(posedge clk) begin
    v3 <= rst ? 1'b0 : v2;
    for (int k = 0; k < 3; k++) begin
      neg3[k] <= diff[k][MW];
      mag3[k] <= diff[k][MW] ? (~diff[k][MW-1:0] + 1'b1) : diff[k][MW-1:0];
    end
    i3 <= i2;
  end

  // stage 4: partial products of the squares
  logic                   v4;
  logic [2:0]             neg4;
  logic [MW-1:0]          hh [0:2];
  logic [MW-1:0]          hl [0:2];
  logic [MW-1:0]          ll [0:2];
  logic [INDEX_WIDTH-1:0] i4 [0:2];

  always_ff @(posedge clk) begin
    v4 <= rst ? 1'b0 : v3;
    for (int k = 0; k < 3; k++) begin
      hh[k] <= mag3[k][MW-1:E] * mag3[k][MW-1:E];
      hl[k] <= mag3[k][MW-1:E] * mag3[k][E-1:0];
      ll[k] <= mag3[k][E-1:0] * mag3[k][E-1:0];
    end
    neg4 <= neg3;
    i4 <= i3;
  end

  // stage 5: squares
  logic                   v5;
  logic [2:0]             neg5;
  logic [SQW-1:0]         sq [0:2];
  logic [INDEX_WIDTH-1:0] i5 [0:2];

  always_ff @(posedge clk) begin
    v5 <= rst ? 1'b0 : v4;
    for (int k = 0; k < 3; k++) begin
      sq[k] <= (SQW'(hh[k]) << (2 * E)) + (SQW'(hl[k]) << (E + 1)) + SQW'(ll[k]);
    end
    neg5 <= neg4;
    i5 <= i4;
  end

  // stage 6 is entry 0 of the search arrays
  logic                    it_v    [0:ITER];
  logic                    it_zero [0:ITER];
  logic [2:0]              it_neg  [0:ITER];
  logic [SW-1:0]           it_s    [0:ITER];
  logic [CW-1:0]           it_r    [0:ITER][0:2];
  logic [CW-1:0]           it_p    [0:ITER][0:2];
  logic [QW-1:0]           it_m    [0:ITER][0:2];
  logic [SNORM_BITS-1:0]   it_q    [0:ITER][0:2];
  logic [INDEX_WIDTH-1:0]  it_i    [0:ITER][0:2];
  logic [SW-1:0]           s_next;

  assign s_next = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);

  always_ff @(posedge clk) begin
    it_v[0] <= rst ? 1'b0 : v5;
    it_s[0] <= s_next;
    it_zero[0] <= (s_next == '0);
    it_neg[0] <= neg5;
    for (int k = 0; k < 3; k++) begin
      it_r[0][k] <= (CW'(sq[k]) << (2 * SNORM_BITS)) - (CW'(sq[k]) << (SNORM_BITS + 1))
                    + CW'(sq[k]);
      it_p[0][k] <= '0;
      it_m[0][k] <= '0;
      it_q[0][k] <= '0;
    end
    it_i[0] <= i5;
  end

  // search stages: one quotient bit each, from the top
  for (genvar i = 0; i < ITER; i++) begin : g_iter
    localparam int B = ITER - 1 - i;
    logic [CW-1:0] trial [0:2];
    logic [2:0]    take;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = it_p[i][k] + (CW'(it_m[i][k]) << (B + 1)) + (CW'(it_s[i]) << (2 * B));
        take[k]  = (trial[k] <= it_r[i][k]);
      end
    end

    always_ff @(posedge clk) begin
      it_v[i+1] <= rst ? 1'b0 : it_v[i];
      it_s[i+1] <= it_s[i];
      it_zero[i+1] <= it_zero[i];
      it_neg[i+1] <= it_neg[i];
      it_r[i+1] <= it_r[i];
      it_i[i+1] <= it_i[i];
      for (int k = 0; k < 3; k++) begin
        it_p[i+1][k] <= take[k] ? trial[k] : it_p[i][k];
        it_m[i+1][k] <= take[k] ? it_m[i][k] + (QW'(it_s[i]) << B) : it_m[i][k];
        it_q[i+1][k] <= take[k] ? it_q[i][k] | (SNORM_BITS'(1) << B) : it_q[i][k];
      end
    end
  end

  // output stage
  logic signed [NORMAL_WIDTH-1:0] nrm [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (it_zero[ITER]) begin
        nrm[k] = '0;
      end else if (it_neg[ITER][k]) begin
        nrm[k] = NORMAL_WIDTH'(0) - NORMAL_WIDTH'(it_q[ITER][k]);
      end else begin
        nrm[k] = NORMAL_WIDTH'(it_q[ITER][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : it_v[ITER];
    normal_x <= nrm[0];
    normal_y <= nrm[1];
    normal_z <= nrm[2];
    out_index_a <= it_i[ITER][0];
    out_index_b <= it_i[ITER][1];
    out_index_c <= it_i[ITER][2];
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transaction did not complete at the pipeline latency");

  a_range_x: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x != 16'sh8000))
    else $error("normal_x outside snorm16 range");

  a_range_yz: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_y != 16'sh8000) && (normal_z != 16'sh8000))
    else $error("normal_y or normal_z outside snorm16 range");
`endif

endmodule

@@ tb/sv/tb_triangle_face_normal_snorm16.sv @@
`timescale 1ns / 1ps
// Testbench for triangle_face_normal_snorm16: directed and random triangles,
// exact predicted normals checked against every done strobe.
// Depends on tfn_pkg and the block itself.
module tb_triangle_face_normal_snorm16;
  import tfn_pkg::*;

  typedef struct {
    logic [INDEX_WIDTH-1:0] ia, ib, ic;
    logic signed [FIELD_WIDTH-1:0] c[9];
  } tri_t;

  typedef struct {
    logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
    logic [INDEX_WIDTH-1:0] ia, ib, ic;
  } face_t;

  localparam int LATENCY = 23;
  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [INDEX_WIDTH-1:0] index_a = '0, index_b = '0, index_c = '0;
  logic signed [FIELD_WIDTH-1:0] ax = '0, ay = '0, az = '0, bx = '0, by_coord = '0, bz = '0;
  logic signed [FIELD_WIDTH-1:0] cx = '0, cy = '0, cz = '0;
  logic signed [NORMAL_WIDTH-1:0] normal_x, normal_y, normal_z;
  logic [INDEX_WIDTH-1:0] out_index_a, out_index_b, out_index_c;

  tri_t pending_tris[$];
  face_t expected_faces[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int degenerate = 0;
  int idle_left = 0;
  int quiet_cycles = 0;
  bit hold_drain = 1'b0;
  bit stim_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  triangle_face_normal_snorm16 DUT (.*);

  function automatic logic [15:0] snorm_component(logic [131:0] sq, logic [131:0] sum);
    logic [191:0] rhs, lhs;
    logic [15:0] q;
    q = '0;
    rhs = 192'(sq) * 192'(32767 * 32767);
    for (int b = 14; b >= 0; b--) begin
      logic [15:0] t;
      t = q | (16'd1 << b);
      lhs = 192'(sum) * 192'(t) * 192'(t);
      if (lhs <= rhs) q = t;
    end
    return q;
  endfunction

  function automatic face_t face_normal(tri_t t);
    face_t f;
    logic signed [65:0] e1[3], e2[3];
    logic signed [131:0] n[3];
    logic [127:0] mag[3];
    logic [131:0] sq[3];
    logic [131:0] sum;
    logic [15:0] q[3];
    for (int k = 0; k < 3; k++) begin
      e1[k] = 66'(t.c[6 + k]) - 66'(t.c[3 + k]);
      e2[k] = 66'(t.c[k]) - 66'(t.c[3 + k]);
    end
    n[0] = 132'(e1[1]) * 132'(e2[2]) - 132'(e1[2]) * 132'(e2[1]);
    n[1] = 132'(e1[2]) * 132'(e2[0]) - 132'(e1[0]) * 132'(e2[2]);
    n[2] = 132'(e1[0]) * 132'(e2[1]) - 132'(e1[1]) * 132'(e2[0]);
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = n[k] < 0 ? 128'(-n[k]) : 128'(n[k]);
      sq[k] = 132'(mag[k]) * 132'(mag[k]);
      sum += sq[k];
    end
    for (int k = 0; k < 3; k++) begin
      q[k] = sum == 0 ? 16'd0 : snorm_component(sq[k], sum);
      if (n[k] < 0) q[k] = -q[k];
    end
    f.nx = q[0];
    f.ny = q[1];
    f.nz = q[2];
    f.ia = t.ia;
    f.ib = t.ib;
    f.ic = t.ic;
    return f;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
    endcase
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    t.ia = $urandom;
    t.ib = $urandom;
    t.ic = $urandom;
    for (int k = 0; k < 9; k++) t.c[k] = rand_coord();
    case ($urandom_range(0, 9))
      0: for (int k = 0; k < 3; k++) t.c[6 + k] = t.c[3 + k];
      1: for (int k = 0; k < 3; k++) t.c[6 + k] = t.c[k];
      2: for (int k = 0; k < 3; k++) t.c[6 + k] = 32'(2 * t.c[k] - t.c[3 + k]);
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_t make_tri(logic [31:0] v[9]);
    tri_t t;
    t.ia = $urandom;
    t.ib = $urandom;
    t.ic = $urandom;
    foreach (v[k]) t.c[k] = v[k];
    return t;
  endfunction

  initial begin
    logic [31:0] mx, mn, one;
    tri_t t;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    pending_tris.push_back(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    pending_tris.push_back(make_tri('{one, 0, 0, 0, 0, 0, 0, one, 0}));
    pending_tris.push_back(make_tri('{0, one, 0, 0, 0, 0, 0, 0, one}));
    pending_tris.push_back(make_tri('{0, 0, one, 0, 0, 0, one, 0, 0}));
    pending_tris.push_back(make_tri('{0, one, 0, 0, 0, 0, one, 0, 0}));
    pending_tris.push_back(make_tri('{mx, mx, mx, mn, mn, mn, mx, mn, mx}));
    pending_tris.push_back(make_tri('{mn, mx, mn, mx, mn, mx, mn, mn, mx}));
    pending_tris.push_back(make_tri('{mx, 0, 0, mn, 0, 0, 0, mx, mn}));
    pending_tris.push_back(make_tri('{mx, mx, mx, mn, mn, mn, mx, mx, mx}));
    pending_tris.push_back(make_tri('{1, 0, 0, 0, 0, 0, 0, 1, 0}));
    pending_tris.push_back(make_tri('{1, 1, 0, 0, 0, 0, 0, 0, 1}));
    pending_tris.push_back(make_tri('{1, 2, 3, 1, 2, 3, 7, 8, 9}));
    pending_tris.push_back(make_tri('{one, one, one, 0, 0, 0, 32'hffff_0000, 0, one}));
    pending_tris.push_back(make_tri('{mn, mn, mn, mn, mn, mn, mn, mn, mn}));
    pending_tris.push_back(make_tri('{'1, '1, '1, 0, 0, 0, 1, '1, 0}));
    t = make_tri('{0, one, 0, 0, 0, 0, one, 0, 0});
    t.ia = '0;
    t.ib = '1;
    t.ic = 32'haaaa_5555;
    pending_tris.push_back(t);
    t.ia = '1;
    t.ib = '0;
    t.ic = 32'h5555_aaaa;
    pending_tris.push_back(t);
    repeat (1550) pending_tris.push_back(random_tri());
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_faces.push_back(face_normal(pending_tris.pop_front()));
        sent <= sent + 1;
      end
      if (hold_drain && expected_faces.size() == 0) hold_drain <= 1'b0;
      if (sent == 700 && !hold_drain && start && !busy) begin
        hold_drain <= 1'b1;
        start <= 1'b0;
      end else if (start && busy) begin
        start <= 1'b1;
      end else if (hold_drain || pending_tris.size() == 0) begin
        start <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_tris.size() > 150 && $urandom_range(0, 7) == 0) begin
        idle_left <= $urandom_range(0, 7);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        index_a <= pending_tris[0].ia;
        index_b <= pending_tris[0].ib;
        index_c <= pending_tris[0].ic;
        ax <= pending_tris[0].c[0];
        ay <= pending_tris[0].c[1];
        az <= pending_tris[0].c[2];
        bx <= pending_tris[0].c[3];
        by_coord <= pending_tris[0].c[4];
        bz <= pending_tris[0].c[5];
        cx <= pending_tris[0].c[6];
        cy <= pending_tris[0].c[7];
        cz <= pending_tris[0].c[8];
      end
    end
  end

  always @(posedge clk) begin
    face_t e;
    if (!rst && done) begin
      if (expected_faces.size() == 0) begin
        $display("%0t: unexpected transaction nx=%0d ny=%0d nz=%0d", $time,
                 normal_x, normal_y, normal_z);
        errors++;
      end else begin
        e = expected_faces.pop_front();
        checked++;
        if (e.nx == 0 && e.ny == 0 && e.nz == 0) degenerate++;
        if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz) begin
          $display("%0t: normal expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)", $time,
                   e.nx, e.ny, e.nz, normal_x, normal_y, normal_z);
          errors++;
        end
        if (out_index_a !== e.ia || out_index_b !== e.ib || out_index_c !== e.ic) begin
          $display("%0t: indices expected %h %h %h actual %h %h %h", $time,
                   e.ia, e.ib, e.ic, out_index_a, out_index_b, out_index_c);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && quiet_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired with %0d transactions outstanding", $time,
               expected_faces.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_tris.size() == 0 && sent > 0);
    wait (expected_faces.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d triangles, checked %0d normals, %0d of them degenerate.",
             sent, checked, degenerate);
    if (errors == 0 && expected_faces.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tfn_pkg.sv
rtl/core/triangle_face_normal_snorm16.sv
tb/sv/tb_triangle_face_normal_snorm16.sv
